### rtl/msr_pkg.sv
package msr_pkg;

  localparam int unsigned BUFFER_WORDS_DEF = 64;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_START    = 2'd1,
    CMD_FEEDBACK = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BEAT   = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    TYPE_INT   = 2'd0,
    TYPE_FLOAT = 2'd1
  } elem_type_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SEND = 2'd1,
    ST_WAIT = 2'd2
  } state_e;

endpackage

### rtl/message_send_with_retransmit.sv
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+------------------------------------------
// request  | in        | in_valid_i / _o    | command, word_index, word_value,
//          |           | in_stall_o         | element_type, dest_rank, send_len, ok
// result   | out       | out_valid_o /      | result_kind, call_is_float, header_rank,
//          |           | out_stall_i        | header_count, beat_data, beat_last, count
//
// a load is written to the buffer at accept; a start puts the header in the output register
// at accept and then one beat per cycle follows while the output is not stalled, both words
// of a beat read at once from an even and an odd buffer bank.
// reset clears control only; the buffer has no reset and needs no clearing.
// output stalls hold the result register and, while beats are in flight, the sender.
module message_send_with_retransmit #(
  parameter int unsigned BUFFER_WORDS = msr_pkg::BUFFER_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [5:0]  word_index_i,
  input  logic [31:0] word_value_i,
  input  logic [1:0]  element_type_i,
  input  logic [31:0] dest_rank_i,
  input  logic [6:0]  send_len_i,
  input  logic        feedback_ok_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic        call_is_float_o,
  output logic [31:0] header_rank_o,
  output logic [6:0]  header_count_o,
  output logic [63:0] beat_data_o,
  output logic        beat_last_o,
  output logic [3:0]  sends_done_count_o
);
  import msr_pkg::*;

  localparam int unsigned BankWords = (BUFFER_WORDS + 1) / 2;
  localparam int unsigned BankAw    = (BankWords > 1) ? $clog2(BankWords) : 1;

  logic [31:0] mem_even [BankWords];
  logic [31:0] mem_odd  [BankWords];
  logic [31:0] rd_even_q, rd_odd_q;

  state_e      state_q, state_d;
  logic [6:0]  saved_count_q;
  logic [3:0]  done_cnt_q;
  logic [BankAw-1:0] beat_q;
  logic [BankAw-1:0] last_idx;
  logic        pend_q, pend_last_q, pend_odd_q;

  logic        out_valid_q;
  logic [1:0]  out_kind_q;
  logic        out_float_q;
  logic [31:0] out_rank_q;
  logic [6:0]  out_count_q;
  logic [63:0] out_data_q;
  logic        out_last_q;
  logic [3:0]  out_done_q;

  cmd_e        cmd;
  logic        accept, busy, out_free, take_pend, issue, issue_last;
  logic        is_load, load_ok, start_ok, start_bad, fb_ok, fb_retry;
  logic [BankAw-1:0] wr_addr, rd_addr;

  assign cmd      = cmd_e'(command_i);
  assign busy     = (state_q == ST_SEND) | pend_q;
  assign in_stall_o = busy | (out_valid_q & out_stall_i);
  assign accept   = in_valid_i & ~in_stall_o;
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign take_pend = pend_q & out_free;
  assign last_idx = BankAw'((saved_count_q - 7'd1) >> 1);

  always_comb begin
    is_load   = accept & (cmd == CMD_LOAD);
    load_ok   = is_load & ({26'd0, word_index_i} < 32'(BUFFER_WORDS));
    start_ok  = 1'b0;
    start_bad = 1'b0;
    fb_ok     = 1'b0;
    fb_retry  = 1'b0;
    if (accept && cmd == CMD_START && state_q == ST_IDLE) begin
      if ((element_type_i != TYPE_INT && element_type_i != TYPE_FLOAT) ||
          send_len_i == 7'd0 || {25'd0, send_len_i} > 32'(BUFFER_WORDS)) begin
        start_bad = 1'b1;
      end else begin
        start_ok = 1'b1;
      end
    end
    if (accept && cmd == CMD_FEEDBACK && state_q == ST_WAIT) begin
      fb_ok    = feedback_ok_i;
      fb_retry = ~feedback_ok_i;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_ok) state_d = ST_SEND;
      ST_SEND: if (issue_last) state_d = ST_WAIT;
      ST_WAIT: begin
        if (fb_ok) state_d = ST_IDLE;
        else if (fb_retry) state_d = ST_SEND;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    issue      = (state_q == ST_SEND) & (~pend_q | take_pend);
    issue_last = issue & (beat_q == last_idx);
    rd_addr    = beat_q;
    wr_addr    = BankAw'(word_index_i[5:1]);
  end

  // buffer banks
  always_ff @(posedge clk_i) begin
    if (load_ok && !word_index_i[0]) mem_even[wr_addr] <= word_value_i;
    if (load_ok && word_index_i[0])  mem_odd[wr_addr]  <= word_value_i;
    if (issue) begin
      rd_even_q <= mem_even[rd_addr];
      rd_odd_q  <= mem_odd[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      saved_count_q <= 7'd0;
      done_cnt_q    <= 4'd0;
      beat_q        <= '0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start_ok) saved_count_q <= send_len_i;
      if (fb_ok) done_cnt_q <= done_cnt_q + 4'd1;
      if (start_ok || fb_retry) beat_q <= '0;
      else if (issue) beat_q <= beat_q + BankAw'(1);
      if (issue) pend_q <= 1'b1;
      else if (take_pend) pend_q <= 1'b0;
      if (take_pend || start_ok || start_bad || fb_ok) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_last_q <= issue_last;
      pend_odd_q  <= saved_count_q[0];
    end
    if (take_pend || start_ok || start_bad || fb_ok) begin
      priority if (take_pend) begin
        out_kind_q  <= KIND_BEAT;
        out_float_q <= 1'b0;
        out_rank_q  <= 32'd0;
        out_count_q <= 7'd0;
        out_data_q  <= {(pend_last_q && pend_odd_q) ? 32'd0 : rd_odd_q, rd_even_q};
        out_last_q  <= pend_last_q;
        out_done_q  <= done_cnt_q;
      end else if (start_ok) begin
        out_kind_q  <= KIND_HEADER;
        out_float_q <= (element_type_i == TYPE_FLOAT);
        out_rank_q  <= dest_rank_i;
        out_count_q <= send_len_i;
        out_data_q  <= 64'd0;
        out_last_q  <= 1'b0;
        out_done_q  <= done_cnt_q;
      end else if (start_bad) begin
        out_kind_q  <= KIND_REJECT;
        out_float_q <= 1'b0;
        out_rank_q  <= 32'd0;
        out_count_q <= 7'd0;
        out_data_q  <= 64'd0;
        out_last_q  <= 1'b1;
        out_done_q  <= done_cnt_q;
      end else begin
        out_kind_q  <= KIND_DONE;
        out_float_q <= 1'b0;
        out_rank_q  <= 32'd0;
        out_count_q <= 7'd0;
        out_data_q  <= 64'd0;
        out_last_q  <= 1'b1;
        out_done_q  <= done_cnt_q + 4'd1;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = out_kind_q;
  assign call_is_float_o    = out_float_q;
  assign header_rank_o      = out_rank_q;
  assign header_count_o     = out_count_q;
  assign beat_data_o        = out_data_q;
  assign beat_last_o        = out_last_q;
  assign sends_done_count_o = out_done_q;

endmodule

### dv/message_send_with_retransmit_tb.sv
module message_send_with_retransmit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msr_pkg::*;

  localparam int DEPTH = BUFFER_WORDS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 130;

  typedef struct {
    cmd_e        cmd;
    logic [5:0]  index;
    logic [31:0] value;
    logic [1:0]  elem;
    logic [31:0] rank;
    logic [6:0]  count;
    logic        ok;
  } request_t;

  typedef struct {
    kind_e       kind;
    logic        is_float;
    logic [31:0] rank;
    logic [6:0]  count;
    logic [63:0] data;
    logic        last;
    logic [3:0]  done;
  } result_t;

  class send_tracker;
    logic [31:0] msg_words [DEPTH];
    bit          loaded [DEPTH];
    bit          waiting;
    logic [6:0]  saved_count;
    logic [3:0]  done_count;
    result_t     link_results [$];
    int          errors;

    function void owe(kind_e kind, logic is_float, logic [31:0] rank, logic [6:0] count,
                      logic [63:0] data, logic last);
      link_results.push_back('{kind, is_float, rank, count, data, last, done_count});
    endfunction

    function void owe_beats();
      logic [63:0] data;
      for (int i = 0; i < saved_count; i += 2) begin
        data = {32'd0, msg_words[i]};
        if (i + 1 < saved_count) data[63:32] = msg_words[i + 1];
        owe(KIND_BEAT, 1'b0, 32'd0, 7'd0, data, (i + 2 >= saved_count));
      end
    endfunction

    function void apply_request(request_t r);
      case (r.cmd)
        CMD_LOAD: begin
          msg_words[r.index] = r.value;
          loaded[r.index] = 1'b1;
        end
        CMD_START: begin
          if (!waiting) begin
            if (r.elem > TYPE_FLOAT || r.count == 0 || r.count > DEPTH) begin
              owe(KIND_REJECT, 1'b0, 32'd0, 7'd0, 64'd0, 1'b1);
            end else begin
              saved_count = r.count;
              waiting = 1'b1;
              owe(KIND_HEADER, r.elem[0], r.rank, r.count, 64'd0, 1'b0);
              owe_beats();
            end
          end
        end
        CMD_FEEDBACK: begin
          if (waiting) begin
            if (r.ok) begin
              done_count++;
              waiting = 1'b0;
              owe(KIND_DONE, 1'b0, 32'd0, 7'd0, 64'd0, 1'b1);
            end else begin
              owe_beats();
            end
          end
        end
        default: ;
      endcase
    endfunction

    function int written_prefix();
      int n;
      n = 0;
      while (n < DEPTH && loaded[n]) n++;
      return n;
    endfunction

    function int pending();
      return link_results.size();
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (link_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual kind %0d data %0h",
                 $time, got.kind, got.data);
        return;
      end
      want = link_results.pop_front();
      compare("result_kind", want.kind, got.kind);
      compare("call_is_float", want.is_float, got.is_float);
      compare("header_rank", want.rank, got.rank);
      compare("header_count", want.count, got.count);
      compare("beat_data", want.data, got.data);
      compare("beat_last", want.last, got.last);
      compare("sends_done_count", want.done, got.done);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = 2'd0;
  logic [5:0]  word_index_i = 6'd0;
  logic [31:0] word_value_i = 32'd0;
  logic [1:0]  element_type_i = 2'd0;
  logic [31:0] dest_rank_i = 32'd0;
  logic [6:0]  send_len_i = 7'd0;
  logic        feedback_ok_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic        call_is_float_o;
  logic [31:0] header_rank_o;
  logic [6:0]  header_count_o;
  logic [63:0] beat_data_o;
  logic        beat_last_o;
  logic [3:0]  sends_done_count_o;

  send_tracker sb = new();
  int send_idle_pct = 31;
  int stall_pct = 59;
  int cycles = 0;

  message_send_with_retransmit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .word_index_i       (word_index_i),
    .word_value_i       (word_value_i),
    .element_type_i     (element_type_i),
    .dest_rank_i        (dest_rank_i),
    .send_len_i         (send_len_i),
    .feedback_ok_i      (feedback_ok_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_kind_o      (result_kind_o),
    .call_is_float_o    (call_is_float_o),
    .header_rank_o      (header_rank_o),
    .header_count_o     (header_count_o),
    .beat_data_o        (beat_data_o),
    .beat_last_o        (beat_last_o),
    .sends_done_count_o (sends_done_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{kind_e'(result_kind_o), call_is_float_o, header_rank_o,
                        header_count_o, beat_data_o, beat_last_o, sends_done_count_o});
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_request(request_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= r.cmd;
    word_index_i   <= r.index;
    word_value_i   <= r.value;
    element_type_i <= r.elem;
    dest_rank_i    <= r.rank;
    send_len_i     <= r.count;
    feedback_ok_i  <= r.ok;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.apply_request(r);
  endtask

  task automatic hold_off();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // mostly well-formed load/start/feedback runs, counts limited to loaded entries
  task automatic make_random(output request_t r, output bit useful);
    int pick;
    int top;
    int lim;
    bit do_load;
    r.cmd   = CMD_LOAD;
    r.index = 6'($urandom);
    r.value = $urandom;
    r.elem  = 2'($urandom);
    r.rank  = $urandom;
    r.count = 7'($urandom);
    r.ok    = 1'($urandom);
    useful  = 1'b1;
    pick    = $urandom_range(99);
    top     = sb.written_prefix();
    do_load = 1'b0;
    if (!sb.waiting) begin
      if (pick < 35 || (pick < 70 && top == 0)) begin
        do_load = 1'b1;
      end else if (pick < 70) begin
        r.cmd  = CMD_START;
        r.elem = 2'($urandom_range(1));
        lim    = (top < 8) ? top : 8;
        r.count = 7'($urandom_range(1, lim));
        if ($urandom_range(9) == 0) r.count = 7'($urandom_range(1, top));
        if ($urandom_range(19) == 0) r.count = 7'(top);
      end else if (pick < 82) begin
        r.cmd = CMD_START;
        case ($urandom_range(2))
          0: r.elem = 2'($urandom_range(3, 2));
          1: r.count = 7'd0;
          default: r.count = 7'($urandom_range(127, DEPTH + 1));
        endcase
      end else if (pick < 90) begin
        r.cmd  = CMD_FEEDBACK;
        useful = 1'b0;
      end else begin
        r.cmd  = CMD_NONE;
        useful = 1'b0;
      end
    end else begin
      if (pick < 30) begin
        do_load = 1'b1;
      end else if (pick < 80) begin
        r.cmd = CMD_FEEDBACK;
        r.ok  = ($urandom_range(99) < 60);
      end else if (pick < 90) begin
        r.cmd  = CMD_START;
        useful = 1'b0;
      end else begin
        r.cmd  = CMD_NONE;
        useful = 1'b0;
      end
    end
    if (do_load && top < DEPTH && $urandom_range(1)) r.index = 6'(top);
  endtask

  initial begin
    request_t r;
    bit useful;
    int done_items;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_request('{CMD_LOAD, 6'd0, 32'hFFFF_FFFF, 2'd3, 32'd0, 7'd0, 1'b0});
    send_request('{CMD_LOAD, 6'd1, 32'h0000_0000, 2'd0, 32'd0, 7'd0, 1'b0});
    send_request('{CMD_LOAD, 6'd2, 32'hA5A5_A5A5, 2'd0, 32'd0, 7'd0, 1'b0});
    send_request('{CMD_LOAD, 6'd63, 32'h5A5A_5A5A, 2'd0, 32'd0, 7'd0, 1'b0});
    send_request('{CMD_FEEDBACK, 6'd0, 32'd0, 2'd0, 32'd0, 7'd0, 1'b1});
    send_request('{CMD_NONE, 6'd0, 32'd0, 2'd0, 32'd0, 7'd1, 1'b0});
    send_request('{CMD_START, 6'd0, 32'd0, 2'd2, 32'd7, 7'd3, 1'b0});
    send_request('{CMD_START, 6'd0, 32'd0, 2'd0, 32'd7, 7'd0, 1'b0});
    send_request('{CMD_START, 6'd0, 32'd0, 2'd1, 32'd7, 7'd65, 1'b0});
    send_request('{CMD_START, 6'd0, 32'd0, 2'd0, 32'd0, 7'd127, 1'b0});
    send_request('{CMD_START, 6'd0, 32'd0, 2'd0, 32'hFFFF_FFFF, 7'd3, 1'b0});
    send_request('{CMD_START, 6'd0, 32'd0, 2'd1, 32'd5, 7'd2, 1'b0});
    send_request('{CMD_FEEDBACK, 6'd0, 32'd0, 2'd0, 32'd0, 7'd0, 1'b0});
    send_request('{CMD_LOAD, 6'd1, 32'h1234_5678, 2'd0, 32'd0, 7'd0, 1'b0});
    send_request('{CMD_FEEDBACK, 6'd0, 32'd0, 2'd0, 32'd0, 7'd0, 1'b0});
    send_request('{CMD_FEEDBACK, 6'd0, 32'd0, 2'd0, 32'd0, 7'd0, 1'b1});
    send_request('{CMD_START, 6'd0, 32'd0, 2'd1, 32'd0, 7'd1, 1'b0});
    send_request('{CMD_FEEDBACK, 6'd0, 32'd0, 2'd0, 32'd0, 7'd0, 1'b1});
    send_request('{CMD_START, 6'd0, 32'd0, 2'd0, 32'h8000_0001, 7'd2, 1'b0});
    send_request('{CMD_FEEDBACK, 6'd0, 32'd0, 2'd0, 32'd0, 7'd0, 1'b1});

    for (int phase_no = 0; phase_no < 3; phase_no++) begin
      case (phase_no)
        0: begin
          send_idle_pct = 31;
          stall_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          stall_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) begin
        make_random(r, useful);
        if ($urandom_range(99) < 2) hold_off();
        send_request(r);
        if (useful) done_items++;
      end
      hold_off();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/msr_pkg.sv
rtl/message_send_with_retransmit.sv
dv/message_send_with_retransmit_tb.sv
